// ===== hdl/rofr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rofr_pkg
// Shared types and constants for the rectangle outline/fill rasterizer.
// ----------------------------------------------------------------------------
package rofr_pkg;

  localparam int MAX_DIM_DEF     = 256;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // widest canvas size (1024) plus one bit, for size compares
  localparam int DIM_CMP_W = 11;
  // coordinates: 24-bit inputs plus sums, or pixel index shifted by up to 16
  localparam int COORD_W   = 28;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_DRAW  = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_OUT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_DRAW,
    JOB_READ,
    JOB_REPLY
  } job_op_t;

  typedef struct packed {
    func_t              func;
    logic signed [23:0] rect_left;
    logic signed [23:0] rect_top;
    logic signed [23:0] rect_width;
    logic signed [23:0] rect_height;
    logic               filled;
    logic [7:0]         paint_char;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] pixel_value;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    job_op_t                    op;
    status_t                    status;
    logic                       fill;
    logic [7:0]                 ch;
    logic [7:0]                 rd_col;
    logic [7:0]                 rd_row;
    logic signed [COORD_W-1:0]  xl;
    logic signed [COORD_W-1:0]  xr;
    logic signed [COORD_W-1:0]  xbl;
    logic signed [COORD_W-1:0]  xbr;
    logic signed [COORD_W-1:0]  yl;
    logic signed [COORD_W-1:0]  yr;
    logic signed [COORD_W-1:0]  ybl;
    logic signed [COORD_W-1:0]  ybr;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/rofr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rofr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rofr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rofr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rofr_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rofr_queue
  import rofr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rofr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rofr_front
// Accepts commands, checks them and turns rectangles into edge bounds.
// ----------------------------------------------------------------------------
module rofr_front
  import rofr_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire cmd_t                             cmd,
  input  wire logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2):0] eff_w,
  input  wire logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2):0] eff_h,
  output logic                                  push,
  output job_t                                  push_data,
  input  wire logic                             q_full
);

  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(2 ** FRAC_BITS);

  logic                       job_valid;
  job_t                       job;
  job_t                       job_next;
  logic                       accept;
  logic signed [COORD_W-1:0]  xl;
  logic signed [COORD_W-1:0]  yl;
  logic signed [COORD_W-1:0]  xr;
  logic signed [COORD_W-1:0]  yr;
  logic                       bad_size;
  logic                       out_range;

  assign push      = job_valid && !q_full;
  assign push_data = job;
  assign busy      = job_valid && q_full;
  assign accept    = start && !busy;

  assign xl = COORD_W'(cmd.rect_left);
  assign yl = COORD_W'(cmd.rect_top);
  assign xr = xl + COORD_W'(cmd.rect_width);
  assign yr = yl + COORD_W'(cmd.rect_height);

  assign bad_size  = cmd.rect_width[23] || (cmd.rect_width == '0) ||
                     cmd.rect_height[23] || (cmd.rect_height == '0);
  assign out_range = (DIM_CMP_W'(cmd.read_col) >= DIM_CMP_W'(eff_w)) ||
                     (DIM_CMP_W'(cmd.read_row) >= DIM_CMP_W'(eff_h));

  always_comb begin
    job_next        = job_t'('0);
    job_next.fill   = cmd.filled;
    job_next.ch     = cmd.paint_char;
    job_next.rd_col = cmd.read_col;
    job_next.rd_row = cmd.read_row;
    job_next.xl     = xl;
    job_next.xr     = xr;
    job_next.xbl    = xl + ONE;
    job_next.xbr    = xr - ONE;
    job_next.yl     = yl;
    job_next.yr     = yr;
    job_next.ybl    = yl + ONE;
    job_next.ybr    = yr - ONE;
    job_next.status = ST_OK;
    case (cmd.func)
      FN_CLEAR: begin
        job_next.op = JOB_CLEAR;
      end
      FN_DRAW: begin
        if (bad_size) begin
          job_next.op     = JOB_REPLY;
          job_next.status = ST_BAD_SIZE;
        end else begin
          job_next.op = JOB_DRAW;
        end
      end
      FN_READ: begin
        if (out_range) begin
          job_next.op     = JOB_REPLY;
          job_next.status = ST_OUT_RANGE;
        end else begin
          job_next.op = JOB_READ;
        end
      end
      default: begin
        job_next.op = JOB_REPLY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
      job       <= job_next;
    end else if (push) begin
      job_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rofr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rofr_back
// Executes queued items: sweeps the canvas for clear and draw, reads pixels,
// and issues one result per item.
// ----------------------------------------------------------------------------
module rofr_back
  import rofr_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2):0] eff_w,
  input  wire logic [$clog2(MAX_DIM > 1 ? MAX_DIM : 2):0] eff_h,
  input  wire logic [7:0]                       bg_char,
  input  wire job_t                             q_head,
  input  wire logic                             q_valid,
  output logic                                  pop,
  output logic                                  done,
  output result_t                               result
);

  localparam int DIMW = $clog2(MAX_DIM > 1 ? MAX_DIM : 2);
  localparam int AW   = 2 * DIMW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ
  } state_t;

  state_t                     state;
  job_t                       job;
  logic [DIMW-1:0]            row;
  logic [DIMW-1:0]            col;
  logic                       last_col;
  logic                       last_row;
  logic signed [COORD_W-1:0]  fc;
  logic signed [COORD_W-1:0]  fr;
  logic signed [COORD_W-1:0]  xl, xr, xbl, xbr, yl, yr, ybl, ybr;
  logic                       covered;
  logic                       border;
  logic                       we;
  logic [7:0]                 wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [7:0]                 rdata;

  assign last_col = ({1'b0, col} == eff_w - 1'b1);
  assign last_row = ({1'b0, row} == eff_h - 1'b1);

  // pixel position in the fixed-point grid
  assign fc = COORD_W'(col) << FRAC_BITS;
  assign fr = COORD_W'(row) << FRAC_BITS;

  assign xl  = job.xl;
  assign xr  = job.xr;
  assign xbl = job.xbl;
  assign xbr = job.xbr;
  assign yl  = job.yl;
  assign yr  = job.yr;
  assign ybl = job.ybl;
  assign ybr = job.ybr;

  assign covered = (fc >= xl) && (fc <= xr) && (fr >= yl) && (fr <= yr);
  // within one unit of any edge
  assign border = (fc < xbl) || (fc > xbr) || (fr < ybl) || (fr > ybr);

  assign we    = (state == S_SWEEP) &&
                 ((job.op == JOB_CLEAR) || (covered && (border || job.fill)));
  assign wdata = (job.op == JOB_CLEAR) ? bg_char : job.ch;

  assign pop   = (state == S_IDLE) && q_valid;
  assign re    = pop && (q_head.op == JOB_READ);
  assign raddr = {DIMW'(q_head.rd_row), DIMW'(q_head.rd_col)};

  rofr_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr ({row, col}),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_head;
            row <= '0;
            col <= '0;
            case (q_head.op)
              JOB_CLEAR, JOB_DRAW: begin
                state <= S_SWEEP;
              end
              JOB_READ: begin
                state <= S_READ;
              end
              default: begin
                done               <= 1'b1;
                result.status      <= q_head.status;
                result.pixel_value <= '0;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (last_col) begin
            col <= '0;
            if (last_row) begin
              done               <= 1'b1;
              result.status      <= ST_OK;
              result.pixel_value <= '0;
              state              <= S_IDLE;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_READ: begin
          done               <= 1'b1;
          result.status      <= ST_OK;
          result.pixel_value <= rdata;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rectangle_outline_fill_raster.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rectangle_outline_fill_raster
// Character canvas with clear, rectangle draw and pixel read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown on result for one cycle with done high, and the
// receiver cannot hold it off. A command waits in the front register, for as
// long as the queue is full, before it is queued. In the back, clear and draw
// sweep the canvas in use through the single write port of the frame memory,
// one pixel per cycle; a read goes through the registered memory read, and a
// rejected or unused command only gives its result. Up to QUEUE_DEPTH commands
// in the queue and one more in the front register wait behind a sweep before
// busy rises. Pixels are undefined until written by a clear or a draw; there
// is no clearing pass after reset.
module rectangle_outline_fill_raster
  import rofr_pkg::*;
#(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cmd_t                 cmd,
  output logic                      done,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int DIMW = $clog2(MAX_DIM > 1 ? MAX_DIM : 2);

  logic [CFG_W-1:0]     canvas_width;
  logic [CFG_W-1:0]     canvas_height;
  logic [7:0]           background_char;
  logic [DIM_CMP_W-1:0] w_ext;
  logic [DIM_CMP_W-1:0] h_ext;
  logic [DIMW:0]        eff_w;
  logic [DIMW:0]        eff_h;
  logic                 push;
  job_t                 push_data;
  logic                 q_full;
  logic                 pop;
  job_t                 q_head;
  logic                 q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= CFG_W'(256);
      canvas_height   <= CFG_W'(256);
      background_char <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width    <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height   <= cfg_data;
        REG_BACKGROUND:    background_char <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // zero is used as one, anything above the maximum as the maximum
  assign w_ext = DIM_CMP_W'(canvas_width);
  assign h_ext = DIM_CMP_W'(canvas_height);

  always_comb begin
    if (w_ext == '0) begin
      eff_w = (DIMW + 1)'(1);
    end else if (w_ext > DIM_CMP_W'(MAX_DIM)) begin
      eff_w = (DIMW + 1)'(MAX_DIM);
    end else begin
      eff_w = w_ext[DIMW:0];
    end
    if (h_ext == '0) begin
      eff_h = (DIMW + 1)'(1);
    end else if (h_ext > DIM_CMP_W'(MAX_DIM)) begin
      eff_h = (DIMW + 1)'(MAX_DIM);
    end else begin
      eff_h = h_ext[DIMW:0];
    end
  end

  rofr_front #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rofr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  rofr_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .bg_char (background_char),
    .q_head  (q_head),
    .q_valid (q_valid),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

// ===== verif/rectangle_outline_fill_raster_tb.sv =====
// ----------------------------------------------------------------------------
// rectangle_outline_fill_raster_tb
// Self-checking bench for the character canvas rasterizer. A behavioral
// canvas tracks every clear, draw and read and predicts each result. The
// bench starts with directed commands: reset state, bounds, bad rectangles,
// fractional edges and canvas resizing. It then sends random commands over
// several canvas settings and idle patterns. Each done pulse is checked
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rectangle_outline_fill_raster_tb;
  import rofr_pkg::*;

  localparam func_t FN_UNUSED = func_t'(2'd3);
  localparam longint FIX_ONE  = longint'(1) << FRAC_BITS_DEF;
  localparam int CMD_BITS     = $bits(cmd_t);

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  cmd_t                 cmd       = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // behavioral canvas and register copies
  logic [7:0] canvas_model [0:MAX_DIM_DEF*MAX_DIM_DEF-1];
  logic [8:0] cfg_width      = 9'd256;
  logic [8:0] cfg_height     = 9'd256;
  logic [7:0] cfg_background = 8'd32;

  result_t pending_results [$];
  result_t expected_result;
  int      mismatch_count = 0;
  int      result_index   = 0;
  int      idle_pct       = 0;

  rectangle_outline_fill_raster uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int dim_in_use(logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  // applies one command to the canvas copy and returns its result
  function automatic result_t apply_command(cmd_t c);
    result_t res;
    longint  x, y, w, h, fc, fr;
    int      cw, ch, r, col;
    bit      border;
    res.status      = ST_OK;
    res.pixel_value = 8'd0;
    cw = dim_in_use(cfg_width);
    ch = dim_in_use(cfg_height);
    case (c.func)
      FN_CLEAR: begin
        for (r = 0; r < ch; r++)
          for (col = 0; col < cw; col++)
            canvas_model[r*MAX_DIM_DEF + col] = cfg_background;
      end
      FN_DRAW: begin
        x = {{40{c.rect_left[23]}}, c.rect_left};
        y = {{40{c.rect_top[23]}}, c.rect_top};
        w = {{40{c.rect_width[23]}}, c.rect_width};
        h = {{40{c.rect_height[23]}}, c.rect_height};
        if (w <= 0 || h <= 0) begin
          res.status = ST_BAD_SIZE;
        end else begin
          for (r = 0; r < ch; r++) begin
            fr = longint'(r) * FIX_ONE;
            if (fr < y || fr > y + h) continue;
            for (col = 0; col < cw; col++) begin
              fc = longint'(col) * FIX_ONE;
              if (fc < x || fc > x + w) continue;
              border = (fc - x < FIX_ONE) || (x + w - fc < FIX_ONE) ||
                       (fr - y < FIX_ONE) || (y + h - fr < FIX_ONE);
              if (border || c.filled)
                canvas_model[r*MAX_DIM_DEF + col] = c.paint_char;
            end
          end
        end
      end
      FN_READ: begin
        if (c.read_col >= cw || c.read_row >= ch)
          res.status = ST_OUT_RANGE;
        else
          res.pixel_value = canvas_model[int'(c.read_row)*MAX_DIM_DEF + int'(c.read_col)];
      end
      default: ;
    endcase
    return res;
  endfunction

  // fields a command does not use still carry random bits
  function automatic cmd_t random_cmd();
    logic [CMD_BITS-1:0] raw;
    raw = CMD_BITS'({$urandom, $urandom, $urandom, $urandom});
    return cmd_t'(raw);
  endfunction

  function automatic cmd_t func_cmd(func_t f);
    cmd_t c;
    c      = random_cmd();
    c.func = f;
    return c;
  endfunction

  function automatic cmd_t draw_cmd(int x, int y, int w, int h, bit fill, logic [7:0] ch);
    cmd_t c;
    c             = func_cmd(FN_DRAW);
    c.rect_left   = x[23:0];
    c.rect_top    = y[23:0];
    c.rect_width  = w[23:0];
    c.rect_height = h[23:0];
    c.filled      = fill;
    c.paint_char  = ch;
    return c;
  endfunction

  function automatic cmd_t read_cmd(int col, int row);
    cmd_t c;
    c          = func_cmd(FN_READ);
    c.read_col = col[7:0];
    c.read_row = row[7:0];
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH result %0d: %s", result_index, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("done with no item pending");
      end else begin
        expected_result = pending_results.pop_front();
        if (result.status !== expected_result.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, expected_result.status));
        if (result.pixel_value !== expected_result.pixel_value)
          report_mismatch($sformatf("pixel_value %0d, expected %0d",
                                    result.pixel_value, expected_result.pixel_value));
      end
      result_index++;
    end
  end

  task automatic issue_command(cmd_t c);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_canvas(logic [8:0] w, logic [8:0] h, logic [7:0] bg);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_BACKGROUND;
    cfg_data  <= {1'($urandom), bg};
    @(posedge clk);
    cfg_we         <= 1'b0;
    cfg_width      = w;
    cfg_height     = h;
    cfg_background = bg;
  endtask

  // full-size clear first so that no read ever hits an unwritten pixel
  task automatic test_reset_state();
    issue_command(func_cmd(FN_CLEAR));
    issue_command(read_cmd(0, 0));
    issue_command(read_cmd(255, 255));
  endtask

  task automatic test_full_canvas_draw();
    issue_command(draw_cmd(640, 768, 64000, 63936, 1'b0, "R"));
    issue_command(read_cmd(252, 252));
    issue_command(read_cmd(100, 100));
  endtask

  task automatic test_bad_rectangles();
    program_canvas(9'd16, 9'd16, ".");
    issue_command(func_cmd(FN_CLEAR));
    issue_command(draw_cmd(0, 0, 0, 256, 1'b1, "X"));
    issue_command(draw_cmd(0, 0, 768, -256, 1'b1, "X"));
    issue_command(draw_cmd(0, 0, -8388608, 8388607, 1'b1, "X"));
    // far outside in either direction: accepted, paints nothing
    issue_command(draw_cmd(-8388608, -8388608, 8388607, 8388607, 1'b1, "X"));
    issue_command(draw_cmd(8388607, 8388607, 8388607, 8388607, 1'b1, "X"));
    issue_command(func_cmd(FN_UNUSED));
  endtask

  task automatic test_small_draws();
    issue_command(draw_cmd(256, 256, 5*256, 4*256, 1'b1, "r"));
    issue_command(draw_cmd(-128, 8*256 + 192, 20*256, 2*256, 1'b0, "#"));
    // one lsb wide: a single column, all border
    issue_command(draw_cmd(12*256, 256, 1, 3*256, 1'b0, "|"));
    issue_command(read_cmd(0, 0));
    issue_command(read_cmd(3, 3));
    issue_command(read_cmd(0, 9));
    issue_command(read_cmd(12, 2));
  endtask

  task automatic test_canvas_bounds();
    program_canvas(9'd0, 9'd0, 8'd0);
    issue_command(func_cmd(FN_CLEAR));
    issue_command(read_cmd(0, 0));
    issue_command(read_cmd(1, 0));
    issue_command(read_cmd(0, 1));
    program_canvas(9'd511, 9'd2, 8'd255);
    issue_command(func_cmd(FN_CLEAR));
    issue_command(read_cmd(255, 1));
    issue_command(read_cmd(0, 2));
  endtask

  // stored pixels keep their position when the canvas shrinks
  task automatic test_resize_keeps();
    program_canvas(9'd8, 9'd8, "z");
    issue_command(read_cmd(3, 3));
    issue_command(read_cmd(8, 0));
  endtask

  task automatic send_random_item();
    cmd_t c;
    int   cw, ch, k, m;
    cw = dim_in_use(cfg_width);
    ch = dim_in_use(cfg_height);
    k  = $urandom_range(0, 99);
    if (k < 8) begin
      c = func_cmd(FN_CLEAR);
    end else if (k < 50) begin
      c = draw_cmd(int'($urandom_range(0, (cw + 4)*256)) - 512,
                   int'($urandom_range(0, (ch + 4)*256)) - 512,
                   int'($urandom_range(1, (cw + 2)*256)),
                   int'($urandom_range(1, (ch + 2)*256)),
                   1'($urandom), 8'($urandom));
      m = $urandom_range(0, 99);
      if (m < 10) begin
        c      = random_cmd();
        c.func = FN_DRAW;
      end else if (m < 15) begin
        c.rect_width = 24'(-int'($urandom_range(0, 2000)));
      end else if (m < 20) begin
        c.rect_height = 24'(-int'($urandom_range(0, 2000)));
      end
    end else if (k < 95) begin
      if ($urandom_range(0, 9) == 0)
        c = read_cmd($urandom_range(0, 255), $urandom_range(0, 255));
      else
        c = read_cmd($urandom_range(0, cw), $urandom_range(0, ch));
    end else begin
      c = func_cmd(FN_UNUSED);
    end
    issue_command(c);
  endtask

  task automatic test_random_phase(int items, int pct);
    logic [8:0] w, h;
    idle_pct = pct;
    repeat (2) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          w = 9'($urandom_range(1, 24));
          h = 9'($urandom_range(1, 24));
        end
        2: begin
          w = 9'($urandom_range(0, 1));
          h = 9'($urandom_range(0, 40));
        end
        3: begin
          w = 9'($urandom_range(257, 511));
          h = 9'($urandom_range(0, 3));
        end
        default: begin
          w = 9'($urandom_range(0, 3));
          h = 9'($urandom_range(256, 511));
        end
      endcase
      program_canvas(w, h, 8'($urandom));
      repeat (items / 2) begin
        if ($urandom_range(0, 19) == 0) wait_results_drained();
        send_random_item();
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_full_canvas_draw();
    test_bad_rectangles();
    test_small_draws();
    test_canvas_bounds();
    test_resize_keeps();
    test_random_phase(18, 0);
    test_random_phase(18, 66);
    test_random_phase(18, 30);
    test_random_phase(18, 66);
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rofr_pkg.sv
hdl/rofr_ram.sv
hdl/rofr_queue.sv
hdl/rofr_front.sv
hdl/rofr_back.sv
hdl/rectangle_outline_fill_raster.sv
verif/rectangle_outline_fill_raster_tb.sv
